[design/prr_pkg.sv]
// Shared types and constants for the polyphase rational resampler.
// Used by prr_seq, prr_mac and polyphase_rational_resampler_top; no dependencies.
package prr_pkg;

  localparam int COEF_BITS  = 16;  // Q1.15 coefficients
  localparam int COEF_FRAC  = 15;
  localparam int UP_BITS    = 7;
  localparam int DOWN_BITS  = 10;
  localparam int TAPS_BITS  = 11;
  localparam int INDEX_BITS = 10;
  localparam int PHASE_BITS = 11;  // holds phase plus one decimation step
  localparam int COUNT_BITS = 7;   // results per sample, up to 64

  localparam logic [1:0] REG_UP   = 2'd0;
  localparam logic [1:0] REG_DOWN = 2'd1;
  localparam logic [1:0] REG_TAPS = 2'd2;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  // Per-cycle commands from the sequencer to the multiply-accumulate path.
  typedef struct packed {
    logic clear;  // zero the accumulator
    logic issue;  // a tap read is in flight this cycle
    logic zero;   // that tap reads history before the first push
    logic scale;  // apply the output gain
    logic round;  // round and saturate into the result register
  } prr_mac_ctrl_t;

endpackage

[design/prr_ram.sv]
// Generic single-port synchronous RAM with a registered read port.
// No dependencies; holds the coefficient and history stores.
module prr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/prr_mac.sv]
// Multiply-accumulate path: tap product, accumulator, gain, round and saturate.
// Depends on prr_pkg; fed by the RAM read ports and commanded by prr_seq.
module prr_mac #(
  parameter int MAX_TAPS    = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  prr_pkg::prr_mac_ctrl_t        ctrl_i,
  input  logic signed [prr_pkg::COEF_BITS-1:0] coef_i,
  input  logic signed [SAMPLE_BITS-1:0] hist_i,
  input  logic [prr_pkg::UP_BITS-1:0]   u_i,
  output logic                          busy_o,
  output logic signed [SAMPLE_BITS-1:0] res_o,
  output logic                          sat_o
);

  localparam int PW  = prr_pkg::COEF_BITS + SAMPLE_BITS;
  localparam int ACW = PW + $clog2(MAX_TAPS);
  localparam int SW  = ACW + prr_pkg::UP_BITS + 1;
  localparam logic signed [SW-1:0] RND = SW'(1) <<< (prr_pkg::COEF_FRAC - 1);
  localparam logic signed [SW-1:0] HI  = {{(SW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SW-1:0] LO  = ~HI;

  logic                          v1_q, v2_q, z1_q;
  logic signed [PW-1:0]          prod_q;
  logic signed [ACW-1:0]         acc_q;
  logic signed [SW-1:0]          scaled_q;
  logic signed [SAMPLE_BITS-1:0] res_q;
  logic                          sat_q;
  logic signed [SAMPLE_BITS-1:0] hsel;
  logic signed [PW-1:0]          prod_w;
  logic signed [SW-1:0]          rnd_w, shf_w;

  // History entries never pushed read as zero.
  assign hsel   = z1_q ? '0 : hist_i;
  assign prod_w = PW'(coef_i) * PW'(hsel);
  assign rnd_w  = scaled_q + RND;
  assign shf_w  = rnd_w >>> prr_pkg::COEF_FRAC;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= ctrl_i.issue;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    z1_q <= ctrl_i.zero;
    if (v1_q) begin
      prod_q <= prod_w;
    end
    if (ctrl_i.clear) begin
      acc_q <= '0;
    end else if (v2_q) begin
      acc_q <= acc_q + ACW'(prod_q);
    end
    if (ctrl_i.scale) begin
      scaled_q <= SW'(acc_q) * SW'($signed({1'b0, u_i}));
    end
    if (ctrl_i.round) begin
      if (shf_w > HI) begin
        res_q <= HI[SAMPLE_BITS-1:0];
        sat_q <= 1'b1;
      end else if (shf_w < LO) begin
        res_q <= LO[SAMPLE_BITS-1:0];
        sat_q <= 1'b1;
      end else begin
        res_q <= shf_w[SAMPLE_BITS-1:0];
        sat_q <= 1'b0;
      end
    end
  end

  assign busy_o = v1_q | v2_q;
  assign res_o  = res_q;
  assign sat_o  = sat_q;

endmodule

[design/prr_seq.sv]
// Sequencer: input transactions, RAM addressing, phase tracking, output register.
// Depends on prr_pkg; drives prr_ram write/read addresses and prr_mac commands.
module prr_seq #(
  parameter int MAX_TAPS    = 1024,
  parameter int MAX_UP      = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [prr_pkg::UP_BITS-1:0]        up_cfg_i,
  input  logic [prr_pkg::DOWN_BITS-1:0]      down_cfg_i,
  input  logic [prr_pkg::TAPS_BITS-1:0]      taps_cfg_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               mode_i,
  input  logic [prr_pkg::INDEX_BITS-1:0]     coef_index_i,
  output logic                               coef_we_o,
  output logic [$clog2(MAX_TAPS)-1:0]        coef_addr_o,
  output logic                               hist_we_o,
  output logic [$clog2(MAX_TAPS)-1:0]        hist_addr_o,
  output prr_pkg::prr_mac_ctrl_t             mac_ctrl_o,
  output logic [prr_pkg::UP_BITS-1:0]        u_eff_o,
  input  logic                               mac_busy_i,
  input  logic signed [SAMPLE_BITS-1:0]      mac_res_i,
  input  logic                               mac_sat_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]      sample_out_o,
  output logic                               last_o,
  output logic                               saturated_o
);

  localparam int AW  = $clog2(MAX_TAPS);
  localparam int KW  = $clog2(MAX_TAPS + MAX_UP + 1);
  localparam int PHW = prr_pkg::PHASE_BITS;
  localparam int CW  = prr_pkg::COUNT_BITS;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_ROUND,
    ST_EMIT
  } state_e;

  state_e                        state_q, state_d;
  logic [PHW-1:0]                phase_q, phase_d;
  logic [AW-1:0]                 head_q, head_d;
  logic [AW:0]                   fill_q, fill_d;
  logic [CW-1:0]                 n_q, n_d;
  logic [KW-1:0]                 k_q, k_d;
  logic [AW-1:0]                 j_q, j_d;
  logic                          out_valid_q, out_valid_d;
  logic signed [SAMPLE_BITS-1:0] out_data_q, out_data_d;
  logic                          last_q, last_d;
  logic                          sat_q, sat_d;

  logic [prr_pkg::UP_BITS-1:0]   u_eff;
  logic [prr_pkg::DOWN_BITS-1:0] d_eff;
  logic [KW-1:0]                 taps_eff;
  logic                          accept, load_acc, smp_acc, issue, is_last, emit_go;
  logic [AW-1:0]                 head_nx, rd_addr;
  logic [PHW-1:0]                phase_sum;
  logic [CW-1:0]                 n_sum;

  // Clamp the registers to their usable ranges.
  always_comb begin
    if (up_cfg_i == '0) begin
      u_eff = prr_pkg::UP_BITS'(1);
    end else if (32'(up_cfg_i) > MAX_UP) begin
      u_eff = prr_pkg::UP_BITS'(MAX_UP);
    end else begin
      u_eff = up_cfg_i;
    end
    d_eff = (down_cfg_i == '0) ? prr_pkg::DOWN_BITS'(1) : down_cfg_i;
    if (taps_cfg_i == '0) begin
      taps_eff = KW'(1);
    end else if (32'(taps_cfg_i) > MAX_TAPS) begin
      taps_eff = KW'(MAX_TAPS);
    end else begin
      taps_eff = KW'(taps_cfg_i);
    end
  end

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign load_acc = accept && (mode_i == prr_pkg::MODE_LOAD);
  assign smp_acc  = accept && (mode_i == prr_pkg::MODE_SAMPLE);
  assign head_nx  = (32'(head_q) == MAX_TAPS - 1) ? '0 : head_q + AW'(1);
  assign rd_addr  = (head_q >= j_q) ? head_q - j_q
                                    : AW'((AW+1)'(head_q) + (AW+1)'(MAX_TAPS) - (AW+1)'(j_q));
  assign issue    = (state_q == ST_ISSUE) && (k_q < taps_eff);

  assign phase_sum = phase_q + PHW'(d_eff);
  assign n_sum     = n_q + CW'(1);
  assign is_last   = !((phase_sum < PHW'(u_eff)) && (n_sum < CW'(MAX_UP)));
  assign emit_go   = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);

  assign coef_we_o   = load_acc && (32'(coef_index_i) < MAX_TAPS);
  assign coef_addr_o = load_acc ? AW'(coef_index_i) : AW'(k_q);
  assign hist_we_o   = smp_acc;
  assign hist_addr_o = smp_acc ? head_nx : rd_addr;

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    head_d      = head_q;
    fill_d      = fill_q;
    n_d         = n_q;
    k_d         = k_q;
    j_d         = j_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    last_d      = last_q;
    sat_d       = sat_q;
    mac_ctrl_o  = '0;
    mac_ctrl_o.issue = issue;
    mac_ctrl_o.zero  = ({1'b0, j_q} >= fill_q);

    case (state_q)
      ST_IDLE: begin
        if (smp_acc) begin
          head_d = head_nx;
          if (32'(fill_q) != MAX_TAPS) begin
            fill_d = fill_q + (AW+1)'(1);
          end
          n_d = '0;
          if (phase_q < PHW'(u_eff)) begin
            k_d              = KW'(phase_q);
            j_d              = '0;
            mac_ctrl_o.clear = 1'b1;
            state_d          = ST_ISSUE;
          end else begin
            // Phase left over from a larger factor: no result, consume the span.
            phase_d = phase_q - PHW'(u_eff);
          end
        end
      end
      ST_ISSUE: begin
        if (issue) begin
          k_d = k_q + KW'(u_eff);
          j_d = j_q + AW'(1);
        end else begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!mac_busy_i) begin
          mac_ctrl_o.scale = 1'b1;
          state_d          = ST_ROUND;
        end
      end
      ST_ROUND: begin
        mac_ctrl_o.round = 1'b1;
        state_d          = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_go) begin
          out_valid_d = 1'b1;
          out_data_d  = mac_res_i;
          sat_d       = mac_sat_i;
          last_d      = is_last;
          n_d         = n_sum;
          if (is_last) begin
            phase_d = phase_sum - PHW'(u_eff);
            state_d = ST_IDLE;
          end else begin
            phase_d          = phase_sum;
            k_d              = KW'(phase_sum);
            j_d              = '0;
            mac_ctrl_o.clear = 1'b1;
            state_d          = ST_ISSUE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= '0;
      head_q      <= '0;
      fill_q      <= '0;
      n_q         <= '0;
      k_q         <= '0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      head_q      <= head_d;
      fill_q      <= fill_d;
      n_q         <= n_d;
      k_q         <= k_d;
      j_q         <= j_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    last_q     <= last_d;
    sat_q      <= sat_d;
  end

  assign in_stall_o   = (state_q != ST_IDLE);
  assign u_eff_o      = u_eff;
  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_data_q;
  assign last_o       = last_q;
  assign saturated_o  = sat_q;

endmodule

[design/polyphase_rational_resampler_top.sv]
// Polyphase rational resampler: register port, coefficient and history RAMs,
// sequencer and MAC path. Depends on prr_pkg, prr_ram, prr_mac, prr_seq.
//
// Usage: program up_factor (0x0), down_factor (0x4) and tap_count (0x8) over
// the APB port while idle. Input transactions with mode 0 load one
// coefficient. Mode 1 pushes a sample and yields zero to MAX_UP result
// transactions, the final one flagged by last_o. Load every coefficient below
// tap_count before pushing samples.
// Each result walks its polyphase branch with one multiply-accumulate a
// cycle, one coefficient and one history word read per cycle from the two
// single-port RAMs, followed by pipeline drain, gain, round and hand-off. A
// sample transaction can be taken once the previous sample's final result
// has entered the output register. in_stall_o is high while results of an
// accepted sample are being computed. A stalled output holds its register;
// the next result waits in the MAC path until the register frees.
// Reset clears the registers to 1, the history to zeros (a fill count masks
// entries never written, no clearing pass) and the phase to zero; coefficients
// are undefined until loaded.
module polyphase_rational_resampler_top #(
  parameter int MAX_TAPS    = 1024,
  parameter int MAX_UP      = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [3:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          mode_i,
  input  logic [9:0]                    coef_index_i,
  input  logic signed [15:0]            coef_value_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0] sample_out_o,
  output logic                          last_o,
  output logic                          saturated_o
);

  localparam int AW = $clog2(MAX_TAPS);

  logic [prr_pkg::UP_BITS-1:0]   up_q;
  logic [prr_pkg::DOWN_BITS-1:0] down_q;
  logic [prr_pkg::TAPS_BITS-1:0] taps_q;
  logic                          cfg_wr;

  logic                          coef_we, hist_we, mac_busy, mac_sat;
  logic [AW-1:0]                 coef_addr, hist_addr;
  logic signed [15:0]            coef_rd;
  logic signed [SAMPLE_BITS-1:0] hist_rd, mac_res;
  logic [prr_pkg::UP_BITS-1:0]   u_eff;
  prr_pkg::prr_mac_ctrl_t        mac_ctrl;

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_q   <= prr_pkg::UP_BITS'(1);
      down_q <= prr_pkg::DOWN_BITS'(1);
      taps_q <= prr_pkg::TAPS_BITS'(1);
    end else if (cfg_wr) begin
      case (paddr[3:2])
        prr_pkg::REG_UP:   up_q   <= pwdata[prr_pkg::UP_BITS-1:0];
        prr_pkg::REG_DOWN: down_q <= pwdata[prr_pkg::DOWN_BITS-1:0];
        prr_pkg::REG_TAPS: taps_q <= pwdata[prr_pkg::TAPS_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      prr_pkg::REG_UP:   prdata = 32'(up_q);
      prr_pkg::REG_DOWN: prdata = 32'(down_q);
      prr_pkg::REG_TAPS: prdata = 32'(taps_q);
      default:           prdata = '0;
    endcase
  end

  prr_ram #(.WIDTH(16), .DEPTH(MAX_TAPS)) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (coef_we),
    .addr_i  (coef_addr),
    .wdata_i (coef_value_i),
    .rdata_o (coef_rd)
  );

  prr_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_TAPS)) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .addr_i  (hist_addr),
    .wdata_i (sample_in_i),
    .rdata_o (hist_rd)
  );

  prr_seq #(.MAX_TAPS(MAX_TAPS), .MAX_UP(MAX_UP), .SAMPLE_BITS(SAMPLE_BITS)) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .up_cfg_i     (up_q),
    .down_cfg_i   (down_q),
    .taps_cfg_i   (taps_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .mode_i       (mode_i),
    .coef_index_i (coef_index_i),
    .coef_we_o    (coef_we),
    .coef_addr_o  (coef_addr),
    .hist_we_o    (hist_we),
    .hist_addr_o  (hist_addr),
    .mac_ctrl_o   (mac_ctrl),
    .u_eff_o      (u_eff),
    .mac_busy_i   (mac_busy),
    .mac_res_i    (mac_res),
    .mac_sat_i    (mac_sat),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sample_out_o (sample_out_o),
    .last_o       (last_o),
    .saturated_o  (saturated_o)
  );

  prr_mac #(.MAX_TAPS(MAX_TAPS), .SAMPLE_BITS(SAMPLE_BITS)) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .coef_i (coef_rd),
    .hist_i (hist_rd),
    .u_i    (u_eff),
    .busy_o (mac_busy),
    .res_o  (mac_res),
    .sat_o  (mac_sat)
  );

  // No tap read may be in flight while new transactions are taken.
  a_idle_no_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !mac_busy)
    else $error("MAC path busy while input is accepted");

  a_issue_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_ctrl.issue |-> in_stall_o && !coef_we && !hist_we)
    else $error("tap read overlaps a RAM write");

  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && saturated_o) |->
      (sample_out_o == {1'b0, {(SAMPLE_BITS-1){1'b1}}} ||
       sample_out_o == {1'b1, {(SAMPLE_BITS-1){1'b0}}}))
    else $error("saturated result is not at full scale");

endmodule
